// ===== hdl/multiplexed_digit_display_scanner_unit_assert.svh =====
// Assertion helpers shared by the scanner RTL.
`ifndef MULTIPLEXED_DIGIT_DISPLAY_SCANNER_UNIT_ASSERT_SVH
`define MULTIPLEXED_DIGIT_DISPLAY_SCANNER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MDDS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MDDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/mdds_pkg.sv =====
package mdds_pkg;

  localparam int DIGITS  = 9;
  localparam int BUF_LEN = 2 * DIGITS;
  localparam int ADDR_W  = (BUF_LEN > 1) ? $clog2(BUF_LEN) : 1;
  // position runs up to BUF_LEN + 1 (lookahead address)
  localparam int POS_W   = $clog2(BUF_LEN + 2);

  localparam int INDEX_W = 5;
  localparam int CHAR_W  = 8;
  localparam int DSEL_W  = 4;
  localparam int S_DATA_W = 16;  // index, char_code
  localparam int M_DATA_W = 16;  // digit_select, char_out, dot_on

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [DSEL_W-1:0] dsel_t;

  localparam char_t CHAR_NUL   = 8'h00;
  localparam char_t CHAR_SPACE = 8'h20;
  localparam char_t CHAR_COMMA = 8'h2C;
  localparam char_t CHAR_DOT   = 8'h2E;
  localparam char_t CHAR_ONE   = 8'h31;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  typedef struct packed {
    logic  en;
    addr_t addr;
    char_t data;
  } wr_req_t;

  // Power-up text: "12345 789" style, zeros beyond DIGITS.
  function automatic char_t reset_char(input addr_t a);
    char_t c;
    if (int'(a) >= DIGITS) begin
      c = CHAR_NUL;
    end else if (int'(a) == 5) begin
      c = CHAR_SPACE;
    end else begin
      c = CHAR_ONE + char_t'(a);
    end
    return c;
  endfunction

  function automatic logic is_dot(input char_t c);
    return (c == CHAR_DOT) || (c == CHAR_COMMA);
  endfunction

endpackage

// ===== hdl/mdds_buf.sv =====
// Text buffer with registered read: two read ports, one write port.
// Per-entry valid bits give the power-up text; last write is forwarded.
module mdds_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mdds_pkg::wr_req_t wr_i,
  input  mdds_pkg::pos_t   rd0_addr_i,
  input  mdds_pkg::pos_t   rd1_addr_i,
  output mdds_pkg::char_t  rd0_data_o,
  output mdds_pkg::char_t  rd1_data_o,
  output mdds_pkg::char_t  head0_o,
  output mdds_pkg::char_t  head1_o
);
  import mdds_pkg::*;

  char_t             mem_q [BUF_LEN];
  logic [BUF_LEN-1:0] vld_q;

  pos_t    ra0_q, ra1_q;
  char_t   rdat0_q, rdat1_q;
  logic    rvld0_q, rvld1_q;
  wr_req_t wr_q;
  char_t   head0_q, head1_q;
  addr_t   idx0, idx1;

  assign idx0 = (int'(rd0_addr_i) < BUF_LEN) ? rd0_addr_i[ADDR_W-1:0] : '0;
  assign idx1 = (int'(rd1_addr_i) < BUF_LEN) ? rd1_addr_i[ADDR_W-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rdat0_q <= mem_q[idx0];
    rdat1_q <= mem_q[idx1];
  end

  // port 1 comes out of reset pointing at the lookahead slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      rvld0_q <= 1'b0;
      rvld1_q <= 1'b0;
      ra0_q   <= '0;
      ra1_q   <= pos_t'(1);
      wr_q    <= '0;
      head0_q <= reset_char(addr_t'(0));
      head1_q <= reset_char(addr_t'(1));
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
        if (int'(wr_i.addr) == 0) head0_q <= wr_i.data;
        if (int'(wr_i.addr) == 1) head1_q <= wr_i.data;
      end
      rvld0_q <= vld_q[idx0];
      rvld1_q <= vld_q[idx1];
      ra0_q   <= rd0_addr_i;
      ra1_q   <= rd1_addr_i;
      wr_q    <= wr_i;
    end
  end

  // out of range reads as NUL; a write in the read cycle wins over the RAM
  always_comb begin
    if (int'(ra0_q) >= BUF_LEN) begin
      rd0_data_o = CHAR_NUL;
    end else if (wr_q.en && (ra0_q == pos_t'(wr_q.addr))) begin
      rd0_data_o = wr_q.data;
    end else if (rvld0_q) begin
      rd0_data_o = rdat0_q;
    end else begin
      rd0_data_o = reset_char(ra0_q[ADDR_W-1:0]);
    end

    if (int'(ra1_q) >= BUF_LEN) begin
      rd1_data_o = CHAR_NUL;
    end else if (wr_q.en && (ra1_q == pos_t'(wr_q.addr))) begin
      rd1_data_o = wr_q.data;
    end else if (rvld1_q) begin
      rd1_data_o = rdat1_q;
    end else begin
      rd1_data_o = reset_char(ra1_q[ADDR_W-1:0]);
    end
  end

  assign head0_o = head0_q;
  assign head1_o = head1_q;

endmodule

// ===== hdl/multiplexed_digit_display_scanner_unit.sv =====
// A tick beat's result beat is registered and valid in the cycle after acceptance.
// Throughput: one beat per cycle, write or tick, while the output is drained.
// Writes give no result beat and take effect for the very next tick.
// Reset (async, active low) restores the power-up text via per-entry valid
// bits, so no clearing pass is needed; scan position and digit return to 0.
module multiplexed_digit_display_scanner_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [4:0] index, [12:5] char_code, [15:13] zero
  input  logic [mdds_pkg::S_DATA_W-1:0] s_axis_tdata_i,
  // [0] op
  input  logic                          s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [3:0] digit_select, [11:4] char_out, [12] dot_on, [15:13] zero
  output logic [mdds_pkg::M_DATA_W-1:0] m_axis_tdata_o
);
  import mdds_pkg::*;

  `include "multiplexed_digit_display_scanner_unit_assert.svh"

  // input beat decode
  op_e                op;
  logic [INDEX_W-1:0] in_index;
  char_t              in_char;
  logic               in_acc, tick_acc;
  wr_req_t            wr_req;

  assign op       = op_e'(s_axis_tuser_i);
  assign in_index = s_axis_tdata_i[INDEX_W-1:0];
  assign in_char  = s_axis_tdata_i[INDEX_W +: CHAR_W];

  // output register frees up when its beat leaves
  logic  out_vld_q, out_vld_d;
  dsel_t dsel_q, dsel_d;
  char_t char_q, char_d;
  logic  dot_q, dot_d;

  assign s_axis_tready_o = !out_vld_q || m_axis_tready_i;
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign tick_acc = in_acc && (op == OP_TICK);

  // out-of-range writes are dropped
  always_comb begin
    wr_req.en   = in_acc && (op == OP_WRITE) && (int'(in_index) < BUF_LEN);
    wr_req.addr = ADDR_W'(in_index);
    wr_req.data = in_char;
  end

  // scan state
  pos_t  rp_q, rp_d;
  dsel_t scan_q, scan_d;

  // buffer always holds [rp_q] and [rp_q + 1] on its read ports
  char_t cur_c, nxt_c, head0, head1;

  mdds_buf u_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (wr_req),
    .rd0_addr_i (rp_d),
    .rd1_addr_i (rp_d + pos_t'(1)),
    .rd0_data_o (cur_c),
    .rd1_data_o (nxt_c),
    .head0_o    (head0),
    .head1_o    (head1)
  );

  // Tick evaluation. NUL at the scan point restarts at buffer start; the two
  // head bytes are kept in flops so the restart needs no second RAM read.
  logic  restart;
  char_t val, look;
  pos_t  pos;
  dsel_t scan_eff;
  logic  look_dot;

  always_comb begin
    restart  = (cur_c == CHAR_NUL);
    val      = restart ? head0 : cur_c;
    // lookahead past the end already reads as NUL, never a dot
    look     = restart ? head1 : nxt_c;
    pos      = restart ? pos_t'(1) : rp_q + pos_t'(1);
    scan_eff = restart ? '0 : scan_q;
    look_dot = is_dot(look);

    rp_d   = rp_q;
    scan_d = scan_q;
    dsel_d = dsel_q;
    char_d = char_q;
    dot_d  = dot_q;
    if (tick_acc) begin
      dsel_d = dsel_t'(DIGITS - 1) - scan_eff;
      char_d = val;
      dot_d  = is_dot(val) || look_dot;
      // dot in lookahead is consumed
      rp_d   = look_dot ? pos + pos_t'(1) : pos;
      scan_d = scan_eff + dsel_t'(1);
      if (scan_eff == dsel_t'(DIGITS - 1)) begin
        // last digit done: wrap to buffer start
        scan_d = '0;
        rp_d   = '0;
      end
    end
    out_vld_d = tick_acc || (out_vld_q && !m_axis_tready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q      <= '0;
      scan_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      rp_q      <= rp_d;
      scan_q    <= scan_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dsel_q <= dsel_d;
    char_q <= char_d;
    dot_q  <= dot_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(M_DATA_W - DSEL_W - CHAR_W - 1){1'b0}}, dot_q, char_q, dsel_q};

  // checks
  `MDDS_ASSERT_NOW(a_rp_range, 1'b1, int'(rp_q) <= BUF_LEN, "read position past buffer end")
  `MDDS_ASSERT_NOW(a_scan_range, 1'b1, int'(scan_q) < DIGITS, "scan digit out of range")
  `MDDS_ASSERT_NEXT(a_tick_result, tick_acc, m_axis_tvalid_o, "tick gave no result beat")
  `MDDS_ASSERT_NEXT(a_dot_char, tick_acc && is_dot(val), dot_q, "dot character without dot flag")

endmodule

// ===== tb/mdds_scan_checker.sv =====
// Watches both stream channels of the scanner, keeps its own copy of the
// text buffer and scan state, and compares every result beat in order.
module mdds_scan_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  input  logic [mdds_pkg::S_DATA_W-1:0] s_tdata_i,
  input  logic                          s_tuser_i,
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  input  logic [mdds_pkg::M_DATA_W-1:0] m_tdata_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            checked_o
);
  import mdds_pkg::*;

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    dsel_t sel;
    char_t ch;
    logic  dot;
  } digit_t;

  char_t       text_mem [BUF_LEN];
  int unsigned rd_pos;
  int unsigned scan_idx;
  digit_t      digit_q [$];
  digit_t      want;
  digit_t      got;
  logic [M_DATA_W-DSEL_W-CHAR_W-2:0] pad;

  function automatic logic is_mark(input char_t c);
    return (c == CHAR_DOT) || (c == CHAR_COMMA);
  endfunction

  function automatic char_t text_at(input int unsigned p);
    return (p < BUF_LEN) ? text_mem[p] : CHAR_NUL;
  endfunction

  // One refresh tick: fetch, restart on NUL, absorb a trailing dot or comma.
  function automatic digit_t scan_step();
    digit_t d;
    char_t  c;
    logic   dot;
    c = text_at(rd_pos);
    rd_pos++;
    if (c == CHAR_NUL) begin
      scan_idx = 0;
      rd_pos   = 0;
      c        = text_at(rd_pos);
      rd_pos++;
    end
    dot = is_mark(c);
    if (rd_pos < BUF_LEN && is_mark(text_mem[rd_pos])) begin
      dot = 1'b1;
      rd_pos++;
    end
    d.sel = dsel_t'(DIGITS - 1 - scan_idx);
    d.ch  = c;
    d.dot = dot;
    scan_idx++;
    if (scan_idx >= DIGITS) begin
      scan_idx = 0;
      rd_pos   = 0;
    end
    return d;
  endfunction

  task automatic report(input string what);
    fail_count_o++;
    if (fail_count_o <= MAX_REPORTS) begin
      $display("%t checker: %s", $realtime, what);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BUF_LEN; i++) begin
        if (i >= DIGITS) begin
          text_mem[i] = CHAR_NUL;
        end else if (i == 5) begin
          text_mem[i] = CHAR_SPACE;
        end else begin
          text_mem[i] = char_t'(CHAR_ONE + i);
        end
      end
      rd_pos    = 0;
      scan_idx  = 0;
      digit_q.delete();
      pending_o = 0;
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        if (op_e'(s_tuser_i) == OP_TICK) begin
          digit_q.push_back(scan_step());
        end else if (s_tdata_i[INDEX_W-1:0] < BUF_LEN) begin
          text_mem[s_tdata_i[INDEX_W-1:0]] = s_tdata_i[INDEX_W +: CHAR_W];
        end
      end
      if (m_tvalid_i && m_tready_i) begin
        got.sel = m_tdata_i[DSEL_W-1:0];
        got.ch  = m_tdata_i[DSEL_W +: CHAR_W];
        got.dot = m_tdata_i[DSEL_W + CHAR_W];
        pad     = m_tdata_i[M_DATA_W-1:DSEL_W+CHAR_W+1];
        checked_o++;
        if (digit_q.size() == 0) begin
          report($sformatf("result beat with none pending: sel=%0d ch=%02h dot=%0b",
                           got.sel, got.ch, got.dot));
        end else begin
          want = digit_q.pop_front();
          if (got !== want || pad !== '0) begin
            report($sformatf({"mismatch: want sel=%0d ch=%02h dot=%0b, ",
                              "got sel=%0d ch=%02h dot=%0b pad=%0h"},
                             want.sel, want.ch, want.dot,
                             got.sel, got.ch, got.dot, pad));
          end
        end
      end
      pending_o = digit_q.size();
    end
  end

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    checked_o    = 0;
  end

endmodule

// ===== tb/tb_top.sv =====
// Top of the scanner bench: clock, reset, stimulus and verdict. All checking
// lives in mdds_scan_checker, which hands back a failure count and the number
// of digit results still owed by the block.
module tb_top;
  import mdds_pkg::*;

  // generous for about 1300 beats, even at worst-case gaps/stalls
  localparam int CYCLE_LIMIT = 500000;
  localparam char_t CHAR_ZERO = 8'h30;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                s_valid = 1'b0;
  logic                s_ready;
  logic [S_DATA_W-1:0] s_data = '0;   // [4:0] index, [12:5] char_code
  logic                s_user = 1'b0; // [0] op
  logic                m_valid;
  logic                m_ready = 1'b0;
  logic [M_DATA_W-1:0] m_data;        // [3:0] digit_select, [11:4] char_out, [12] dot_on

  int fails;
  int pending;
  int checked;
  int cycles = 0;

  // Idle knobs, changed per phase by the stimulus process.
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  // Long receiver hold-off request; the sink process consumes it.
  int hold_req = 0;

  int ticks_sent = 0;
  int writes_sent = 0;
  int writes_dropped = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  multiplexed_digit_display_scanner_unit i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  mdds_scan_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_valid),
    .s_tready_i   (s_ready),
    .s_tdata_i    (s_data),
    .s_tuser_i    (s_user),
    .m_tvalid_i   (m_valid),
    .m_tready_i   (m_ready),
    .m_tdata_i    (m_data),
    .fail_count_o (fails),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Receiver side: random stalls at the falling edge, or a long hold-off when
  // the stimulus asks for one, counted down here cycle by cycle.
  initial begin : sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        m_ready <= 1'b0;
        hold_left--;
      end else begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Character mix: digits, dot marks, spaces, the odd NUL and raw bytes.
  function automatic char_t pick_char();
    case ($urandom_range(9))
      0, 1, 2, 3: return char_t'(CHAR_ZERO + $urandom_range(9));
      4:          return CHAR_DOT;
      5:          return CHAR_COMMA;
      6:          return CHAR_SPACE;
      7:          return CHAR_NUL;
      default:    return char_t'($urandom_range(255));
    endcase
  endfunction

  // Offer one beat from a falling edge, with random idle cycles in front,
  // and hold it until the rising edge that accepts it. Valid stays high on
  // exit so back-to-back beats need no extra assignment.
  task automatic send_beat(input op_e op, input logic [INDEX_W-1:0] idx, input char_t ch);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      s_valid <= 1'b0;
      @(negedge clk);
    end
    s_valid <= 1'b1;
    s_user  <= op;
    s_data  <= S_DATA_W'({ch, idx});
    do @(posedge clk); while (!s_ready);
    if (op == OP_TICK) begin
      ticks_sent++;
    end else if (idx < BUF_LEN) begin
      writes_sent++;
    end else begin
      writes_dropped++;
    end
  endtask

  // Tick payload is don't-care for the block; random keeps its bits moving.
  task automatic send_tick();
    send_beat(OP_TICK, INDEX_W'($urandom_range(31)), char_t'($urandom_range(255)));
  endtask

  // Drop valid and wait for every digit result to come back.
  task automatic drain();
    @(negedge clk);
    s_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin : stim
    int set;
    int goal;
    int len;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Power-up text through one full scan and into the wrap.
    repeat (10) send_tick();
    // Out-of-range writes are dropped, including the all-ones index.
    send_beat(OP_WRITE, 5'd31, 8'h41);
    send_beat(OP_WRITE, INDEX_W'(BUF_LEN), CHAR_NUL);
    // Comma and dot as characters, all-ones byte near the start and at the end of the buffer.
    send_beat(OP_WRITE, 5'd0, CHAR_COMMA);
    send_beat(OP_WRITE, 5'd1, CHAR_DOT);
    send_beat(OP_WRITE, 5'd2, 8'hFF);
    send_beat(OP_WRITE, INDEX_W'(BUF_LEN - 1), 8'hFF);
    repeat (3) send_tick();
    // Empty text: NUL at buffer start, so the restart shows a blank digit.
    send_beat(OP_WRITE, 5'd0, CHAR_NUL);
    repeat (6) send_tick();

    // Random part in eight sets, cycling through the four idle patterns.
    for (set = 0; set < 8; set++) begin
      case (set % 4)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 47; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 47; end
        default: begin src_idle_pct = 6;  sink_stall_pct = 6;  end
      endcase
      if (set == 0) begin
        // Receiver holds off while ticks keep coming: output fills, input stalls.
        hold_req = 80;
        repeat (30) send_tick();
      end
      goal = 26 + (set + 1) * 153;
      while (ticks_sent + writes_sent < goal) begin
        if ($urandom_range(9) < 8) begin
          // Well-formed: fresh text from position 0, mostly NUL-terminated,
          // then enough ticks to scan and often wrap it.
          len = $urandom_range(BUF_LEN - 1);
          for (int n = 0; n < len; n++) begin
            send_beat(OP_WRITE, INDEX_W'(n), pick_char());
          end
          if ($urandom_range(3) != 0) begin
            send_beat(OP_WRITE, INDEX_W'(len), CHAR_NUL);
          end
          repeat ($urandom_range(4, 2 * DIGITS + 2)) send_tick();
        end else begin
          // Noise: any op, any index (out of range too), any byte.
          repeat ($urandom_range(1, 6)) begin
            send_beat(op_e'($urandom_range(1)), INDEX_W'($urandom_range(31)),
                      char_t'($urandom_range(255)));
          end
        end
      end
      // Sender pauses until the block has returned every result.
      drain();
    end

    repeat (8) @(posedge clk);
    $display("tb_top: %0d ticks, %0d buffer writes, %0d dropped writes over 4 idle patterns",
             ticks_sent, writes_sent, writes_dropped);
    $display("tb_top: %0d digit results compared, %0d failures", checked, fails);
    if (fails == 0 && pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
